>>> design/ppmcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppmcd_pkg: shared types and constants of the PPM capture decoder
// Gap thresholds in microseconds, register map and the per-request tag that
// travels down the decoder pipeline beside the arithmetic.
// ----------------------------------------------------------------------------
package ppmcd_pkg;

    localparam int CAP_W   = 16;  // capture timestamp width
    localparam int GAP_W   = 15;  // gap in microseconds after halving
    localparam int DEV_W   = 12;  // signed deviation from centre, channel gaps only
    localparam int GAIN_W  = 7;   // gain setting register width
    localparam int FACT_W  = 8;   // gain setting plus ten
    localparam int PROD_W  = 18;  // signed deviation times factor
    localparam int MAG_W   = 16;  // magnitude of that product
    localparam int RECIP_W = 17;  // reciprocal of ten, scaled by 2^19
    localparam int RSHIFT  = 19;
    localparam int QUOT_W  = 14;  // magnitude of the quotient before saturation
    localparam int IDX_W   = 3;
    localparam int VAL_W   = 13;

    localparam logic [GAP_W-1:0] SYNC_LO   = GAP_W'(4000);
    localparam logic [GAP_W-1:0] SYNC_HI   = GAP_W'(19000);
    localparam logic [GAP_W-1:0] CHAN_LO   = GAP_W'(800);
    localparam logic [GAP_W-1:0] CHAN_HI   = GAP_W'(2200);
    localparam logic [GAP_W:0]   CENTRE_US = (GAP_W+1)'(1500);
    localparam logic signed [FACT_W-1:0] GAIN_BASE = FACT_W'(10);
    localparam logic [RECIP_W-1:0] RECIP_TEN = RECIP_W'(52429);

    localparam logic [QUOT_W-1:0] POS_LIMIT = QUOT_W'(4095);
    localparam logic [QUOT_W-1:0] NEG_LIMIT = QUOT_W'(4096);
    localparam logic signed [VAL_W-1:0] VAL_MAX = 13'sd4095;
    localparam logic signed [VAL_W-1:0] VAL_MIN = -13'sd4096;

    // Register map: the index is the word address.
    localparam logic REG_GAIN = 1'b0;

    typedef struct packed {
        logic             sync_seen;
        logic             channel_valid;
        logic             frame_lost;
        logic [IDX_W-1:0] channel_index;
    } t_tag;

endpackage

>>> design/ppm_capture_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppm_capture_decoder_core: PPM stream decoder working on edge timestamps
// Classifies each capture gap as sync, channel or loss and scales channel
// values by the programmable gain setting.
// ----------------------------------------------------------------------------
// The decoder takes one capture request per clock cycle while the output side
// is not stalled, and returns one result for each accepted request.
// There are three register stages: gap classification and frame
// tracking, the gain multiply, and the divide by ten done as a reciprocal
// multiply with saturation. Frame state is updated as a request is accepted,
// so back-to-back captures are decoded correctly. Write gain_setting (word 0)
// only while no request is in flight.
module ppm_capture_decoder_core #(
    parameter int CHANNEL_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // capture stream; tdata [15:0] capture_time
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    // result stream; tdata [2:0] channel_index, [15:3] channel_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    // tuser [0] sync_seen, [1] channel_valid, [2] frame_lost
    output logic [2:0]  m_axis_tuser,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int POS_W = $clog2(CHANNEL_COUNT + 2);
    localparam int IDX_SRC_W = (POS_W > ppmcd_pkg::IDX_W) ? POS_W : ppmcd_pkg::IDX_W;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic signed [ppmcd_pkg::GAIN_W-1:0] r_gain;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= '0;
        end else if (psel && penable && pwrite && pready && (paddr[2] == ppmcd_pkg::REG_GAIN)) begin
            r_gain <= pwdata[ppmcd_pkg::GAIN_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == ppmcd_pkg::REG_GAIN) begin
            prdata = {{(32-ppmcd_pkg::GAIN_W){r_gain[ppmcd_pkg::GAIN_W-1]}}, r_gain};
        end else begin
            prdata = '0;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3;
    logic w_en1, w_en2, w_en3;
    logic w_accept;

    assign w_en3 = !r_v3 || m_axis_tready;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign s_axis_tready = w_en1;
    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= w_accept;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: gap measurement, classification and frame tracking
    // ------------------------------------------------------------------
    logic [ppmcd_pkg::CAP_W-1:0] r_prev_cap, n_prev_cap;
    logic [POS_W-1:0]            r_pos, n_pos;

    logic [ppmcd_pkg::CAP_W-1:0] w_diff;
    logic [ppmcd_pkg::GAP_W-1:0] w_gap;
    logic [ppmcd_pkg::GAP_W:0]   w_dev_full;
    logic [IDX_SRC_W-1:0]        w_pos_m1;
    logic                        w_sync, w_taking, w_in_chan;
    ppmcd_pkg::t_tag             w_tag;
    logic signed [ppmcd_pkg::DEV_W-1:0] w_dev;

    assign w_diff     = s_axis_tdata - r_prev_cap;
    assign w_gap      = w_diff[ppmcd_pkg::CAP_W-1:1];
    assign w_dev_full = {1'b0, w_gap} - ppmcd_pkg::CENTRE_US;
    assign w_pos_m1   = IDX_SRC_W'(r_pos) - IDX_SRC_W'(1);

    assign w_sync    = (w_gap > ppmcd_pkg::SYNC_LO) && (w_gap < ppmcd_pkg::SYNC_HI);
    assign w_taking  = (r_pos != '0) && (r_pos <= POS_W'(CHANNEL_COUNT));
    assign w_in_chan = (w_gap > ppmcd_pkg::CHAN_LO) && (w_gap < ppmcd_pkg::CHAN_HI);

    always_comb begin
        w_tag.sync_seen     = w_sync;
        w_tag.channel_valid = !w_sync && w_taking && w_in_chan;
        w_tag.frame_lost    = !w_sync && w_taking && !w_in_chan;
        w_tag.channel_index = w_tag.channel_valid ? w_pos_m1[ppmcd_pkg::IDX_W-1:0] : '0;
        // A zero deviation makes every non-channel result carry a zero value.
        w_dev = w_tag.channel_valid ? w_dev_full[ppmcd_pkg::DEV_W-1:0] : '0;
    end

    always_comb begin
        n_prev_cap = r_prev_cap;
        n_pos      = r_pos;
        if (w_accept) begin
            n_prev_cap = s_axis_tdata;
            if (w_tag.sync_seen) begin
                n_pos = POS_W'(1);
            end else if (w_tag.channel_valid) begin
                n_pos = r_pos + POS_W'(1);
            end else if (w_tag.frame_lost) begin
                n_pos = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_cap <= '0;
            r_pos      <= '0;
        end else begin
            r_prev_cap <= n_prev_cap;
            r_pos      <= n_pos;
        end
    end

    ppmcd_pkg::t_tag                    r_tag1;
    logic signed [ppmcd_pkg::DEV_W-1:0] r_dev1;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_tag1 <= w_tag;
            r_dev1 <= w_dev;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: deviation times (gain setting + 10)
    // ------------------------------------------------------------------
    logic signed [ppmcd_pkg::FACT_W-1:0]                  w_factor;
    logic signed [ppmcd_pkg::DEV_W+ppmcd_pkg::FACT_W-1:0] w_prod;
    ppmcd_pkg::t_tag                                      r_tag2;
    logic signed [ppmcd_pkg::PROD_W-1:0]                  r_prod2;

    assign w_factor = {r_gain[ppmcd_pkg::GAIN_W-1], r_gain} + ppmcd_pkg::GAIN_BASE;
    assign w_prod   = r_dev1 * w_factor;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_tag2  <= r_tag1;
            r_prod2 <= w_prod[ppmcd_pkg::PROD_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: divide by ten toward zero, then saturate to 13 bits
    // ------------------------------------------------------------------
    logic                                 w_neg;
    logic [ppmcd_pkg::PROD_W-1:0]         w_abs;
    logic [ppmcd_pkg::MAG_W+ppmcd_pkg::RECIP_W-1:0] w_scaled;
    logic [ppmcd_pkg::QUOT_W-1:0]         w_quot;
    logic signed [ppmcd_pkg::VAL_W-1:0]   w_value;
    ppmcd_pkg::t_tag                      r_tag3;
    logic signed [ppmcd_pkg::VAL_W-1:0]   r_value3;

    assign w_neg    = r_prod2[ppmcd_pkg::PROD_W-1];
    assign w_abs    = w_neg ? (~r_prod2 + 1'b1) : r_prod2;
    // The magnitude stays below 2^16, where this reciprocal gives the exact floor.
    assign w_scaled = w_abs[ppmcd_pkg::MAG_W-1:0] * ppmcd_pkg::RECIP_TEN;
    assign w_quot   = w_scaled[ppmcd_pkg::RSHIFT +: ppmcd_pkg::QUOT_W];

    always_comb begin
        if (!w_neg && (w_quot > ppmcd_pkg::POS_LIMIT)) begin
            w_value = ppmcd_pkg::VAL_MAX;
        end else if (w_neg && (w_quot > ppmcd_pkg::NEG_LIMIT)) begin
            w_value = ppmcd_pkg::VAL_MIN;
        end else if (w_neg) begin
            w_value = -$signed(w_quot[ppmcd_pkg::VAL_W-1:0]);
        end else begin
            w_value = w_quot[ppmcd_pkg::VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_tag3   <= r_tag2;
            r_value3 <= w_value;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {r_value3, r_tag3.channel_index};
    assign m_axis_tuser  = {r_tag3.frame_lost, r_tag3.channel_valid, r_tag3.sync_seen};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $countones(m_axis_tuser) <= 1)
        else $error("more than one result kind flagged");

    a_zero_when_no_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[1]) |-> (m_axis_tdata == '0))
        else $error("channel fields non-zero without a channel");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(CHANNEL_COUNT + 1))
        else $error("frame position out of range");

    a_sync_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_sync) |=> (r_pos == POS_W'(1)))
        else $error("sync gap did not arm the frame");

endmodule
